>>> hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: shared package
// Operation codes, register indexes, pixel constants, the item and result
// records and the command and status records between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [7:0]  DIM_RESET     = 8'd128;
  localparam logic [31:0] BLACK_PIXEL   = 32'h0000_00FF;
  localparam logic [23:0] ERR_SAT       = 24'hFF_FFFF;
  localparam logic [24:0] BEST_ALL_ONES = 25'h1FF_FFFF;
  localparam int          DIFF_W        = 10;

  typedef struct packed {
    op_t         op;
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [31:0] pixel_value;
    logic [6:0]  corner_x_a;
    logic [6:0]  corner_x_b;
    logic [6:0]  corner_y_a;
    logic [6:0]  corner_y_b;
    logic [31:0] paint_color;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [23:0] candidate_error;
    logic [24:0] best_error;
    logic [31:0] read_pixel;
  } result_t;

  typedef struct packed {
    logic clr_en;
    logic cap_item;
    logic load_en;
    logic read_en;
    logic scan_start;
    logic scan_en;
    logic decide;
    logic paint_start;
    logic paint_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic area_empty;
    logic scan_last;
    logic pipe_busy;
    logic lower;
    logic rect_empty;
    logic paint_last;
  } status_t;

  function automatic logic [DIFF_W-1:0] pixel_diff(input logic [31:0] p,
                                                   input logic [31:0] q);
    logic [7:0]        a;
    logic [7:0]        b;
    logic [DIFF_W-1:0] sum;
    sum = '0;
    for (int s = 0; s < 4; s++) begin
      a = p[8*s +: 8];
      b = q[8*s +: 8];
      sum = sum + DIFF_W'((a > b) ? (a - b) : (b - a));
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rhc_if.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: channel interfaces
// Item, result and configuration channels, each a valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_item_if;
  logic              valid;
  logic              ready;
  rhc_pkg::op_t      op;
  logic [6:0]        pixel_x;
  logic [6:0]        pixel_y;
  logic [31:0]       pixel_value;
  logic [6:0]        corner_x_a;
  logic [6:0]        corner_x_b;
  logic [6:0]        corner_y_a;
  logic [6:0]        corner_y_b;
  logic [31:0]       paint_color;

  modport source (output valid, op, pixel_x, pixel_y, pixel_value, corner_x_a,
                  corner_x_b, corner_y_a, corner_y_b, paint_color, input ready);
  modport sink (input valid, op, pixel_x, pixel_y, pixel_value, corner_x_a,
                corner_x_b, corner_y_a, corner_y_b, paint_color, output ready);
endinterface

interface rhc_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [23:0] candidate_error;
  logic [24:0] best_error;
  logic [31:0] read_pixel;

  modport source (output valid, accepted, candidate_error, best_error, read_pixel,
                  input ready);
  modport sink (input valid, accepted, candidate_error, best_error, read_pixel,
                output ready);
endinterface

interface rhc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rhc_pkg::CFG_INDEX_W-1:0] index;
  logic [7:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/rhc_datapath.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: datapath
// Image stores, scan and paint counters, error pipeline, best error and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rhc_pkg::item_t            item_data,
  input  wire logic                      cfg_we,
  input  wire logic [rhc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                cfg_data,
  input  wire rhc_pkg::cmd_t             cmd,
  output rhc_pkg::status_t               st,
  output rhc_pkg::result_t               res
);
  import rhc_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW0   = (WW > HW) ? WW : HW;
  localparam int RW    = (RW0 > 8) ? RW0 : 8;

  item_t             it;
  logic [7:0]        img_w;
  logic [7:0]        img_h;
  logic [RW-1:0]     eff_w;
  logic [RW-1:0]     eff_h;
  logic [RW-1:0]     x0;
  logic [RW-1:0]     x1;
  logic [RW-1:0]     y0;
  logic [RW-1:0]     y1;
  logic [RW-1:0]     xa;
  logic [RW-1:0]     xb;
  logic [RW-1:0]     ya;
  logic [RW-1:0]     yb;
  logic [RW-1:0]     xhi;
  logic [RW-1:0]     yhi;
  logic [RW-1:0]     px_r;
  logic [RW-1:0]     py_r;
  logic [RW-1:0]     xc_r;
  logic [RW-1:0]     yc_r;
  logic              px_ok;
  logic [AW-1:0]     pix_addr;
  logic [AW-1:0]     cnt_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;
  logic [XW-1:0]     xc;
  logic [YW-1:0]     yc;
  logic [AW-1:0]     clr_addr;
  logic [31:0]       target_mem [DEPTH];
  logic [31:0]       approx_mem [DEPTH];
  logic [31:0]       rd_target;
  logic [31:0]       rd_approx;
  logic              in_rect;
  logic              scan_x_last;
  logic              paint_x_last;
  logic              v1;
  logic              inside1;
  logic              v2;
  logic [DIFF_W-1:0] dsum;
  logic [23:0]       acc;
  logic [24:0]       acc_sum;
  logic [24:0]       best;
  logic              lower;
  logic              acc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= DIM_RESET;
      img_h <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_w <= cfg_data;
        REG_IMAGE_HEIGHT: img_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      it <= item_data;
    end
  end

  always_comb begin
    eff_w = (RW'(img_w) < RW'(MAX_WIDTH)) ? RW'(img_w) : RW'(MAX_WIDTH);
    eff_h = (RW'(img_h) < RW'(MAX_HEIGHT)) ? RW'(img_h) : RW'(MAX_HEIGHT);
    xa = RW'(it.corner_x_a);
    xb = RW'(it.corner_x_b);
    ya = RW'(it.corner_y_a);
    yb = RW'(it.corner_y_b);
    xhi = (xa < xb) ? xb : xa;
    yhi = (ya < yb) ? yb : ya;
    px_r = RW'(it.pixel_x);
    py_r = RW'(it.pixel_y);
    px_ok = (px_r < RW'(MAX_WIDTH)) && (py_r < RW'(MAX_HEIGHT));
    pix_addr = {py_r[YW-1:0], px_r[XW-1:0]};
    xc_r = RW'(xc);
    yc_r = RW'(yc);
    cnt_addr = {yc, xc};
    rd_addr = cmd.scan_en ? cnt_addr : pix_addr;
    wr_addr = cmd.clr_en ? clr_addr : cnt_addr;
    wr_data = cmd.clr_en ? BLACK_PIXEL : it.paint_color;
    in_rect = (xc_r >= x0) && (xc_r < x1) && (yc_r >= y0) && (yc_r < y1);
    scan_x_last = (xc_r + RW'(1)) == eff_w;
    paint_x_last = (xc_r + RW'(1)) == x1;
    acc_sum = {1'b0, acc} + 25'(dsum);
    lower = {1'b0, acc} < best;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      x0 <= (xa < xb) ? xa : xb;
      y0 <= (ya < yb) ? ya : yb;
      x1 <= (xhi > eff_w) ? eff_w : xhi;
      y1 <= (yhi > eff_h) ? eff_h : yhi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      xc <= '0;
      yc <= '0;
    end else if (cmd.scan_en) begin
      if (scan_x_last) begin
        xc <= '0;
        yc <= yc + YW'(1);
      end else begin
        xc <= xc + XW'(1);
      end
    end else if (cmd.paint_start) begin
      xc <= x0[XW-1:0];
      yc <= y0[YW-1:0];
    end else if (cmd.paint_en) begin
      if (paint_x_last) begin
        xc <= x0[XW-1:0];
        yc <= yc + YW'(1);
      end else begin
        xc <= xc + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && px_ok) begin
      target_mem[pix_addr] <= it.pixel_value;
    end
    if (cmd.scan_en) begin
      rd_target <= target_mem[cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en || cmd.paint_en) begin
      approx_mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_en || cmd.read_en) begin
      rd_approx <= approx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    inside1 <= in_rect;
    dsum <= pixel_diff(inside1 ? it.paint_color : rd_approx, rd_target);
    if (cmd.scan_start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= (acc_sum > {1'b0, ERR_SAT}) ? ERR_SAT : acc_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= BEST_ALL_ONES;
    end else if (cmd.decide && lower) begin
      best <= {1'b0, acc};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      acc_ok <= lower;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.accepted <= (it.op == OP_STEP) && acc_ok;
      res.candidate_error <= (it.op == OP_STEP) ? acc : '0;
      res.best_error <= best;
      res.read_pixel <= ((it.op == OP_READ) && px_ok) ? rd_approx : '0;
    end
  end

  always_comb begin
    st.op = it.op;
    st.clr_done = &clr_addr;
    st.area_empty = (eff_w == '0) || (eff_h == '0);
    st.scan_last = scan_x_last && ((yc_r + RW'(1)) == eff_h);
    st.pipe_busy = v1 || v2;
    st.lower = lower;
    st.rect_empty = !((x0 < x1) && (y0 < y1));
    st.paint_last = paint_x_last && ((yc_r + RW'(1)) == y1);
  end

`ifndef ASSERT_OFF
  a_best_never_rises: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> best <= $past(best))
    else $error("best error rose after a decision");

  a_paint_in_rect: assert property (@(posedge clk) disable iff (rst)
    cmd.paint_en |-> in_rect)
    else $error("paint write outside the rectangle");

  a_decide_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (!v1 && !v2))
    else $error("decision taken before the error pipeline drained");
`endif

endmodule

`default_nettype wire

>>> hdl/rhc_ctrl.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: controller
// Sequences the clearing pass, loads, reads, the error scan, the decision,
// the paint pass and the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire rhc_pkg::status_t st,
  output rhc_pkg::cmd_t         cmd
);
  import rhc_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_DISPATCH = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_DRAIN    = 8'b0001_0000,
    ST_DECIDE   = 8'b0010_0000,
    ST_PAINT    = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.cap_item = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (st.op)
          OP_LOAD: begin
            cmd.load_en = 1'b1;
            state_next = ST_RESP;
          end
          OP_READ: begin
            cmd.read_en = 1'b1;
            state_next = ST_RESP;
          end
          OP_STEP: begin
            cmd.scan_start = 1'b1;
            state_next = st.area_empty ? ST_DECIDE : ST_SCAN;
          end
          default: begin
            state_next = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.lower && !st.rect_empty) begin
          cmd.paint_start = 1'b1;
          state_next = ST_PAINT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_PAINT: begin
        cmd.paint_en = 1'b1;
        if (st.paint_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result_valid = out_valid;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || result_ready))
    else $error("result register loaded while a result was still waiting");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && !st.clr_done) |=> state == ST_CLEAR)
    else $error("clearing pass left before the last entry");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESP))
    else $error("result appeared outside the response state");
`endif

endmodule

`default_nettype wire

>>> hdl/rectangle_hill_climb_image_fit_top.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: top level
// Compares a proposed painted rectangle against a target image and keeps it
// when the total absolute RGBA error falls below the best so far.
// ----------------------------------------------------------------------------
// Load, read and idle items go from dispatch straight to the response state.
// A step scans the active area for its error through the single read port
// of each image store, then paints the rectangle area when the rectangle is kept.
// One item is in progress at a time; a waiting result holds back only the next.
// After reset a clearing pass paints all 2**(XW+YW) entries (16384 at the default
// sizes) of the approximation black; no item is taken meanwhile.
`default_nettype none

module rectangle_hill_climb_image_fit_top #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic clk,
  input  wire logic rst,
  rhc_item_if.sink     item,
  rhc_result_if.source result,
  rhc_cfg_if.sink      cfg
);
  import rhc_pkg::*;

  item_t   item_data;
  result_t res;
  cmd_t    cmd;
  status_t st;

  always_comb begin
    item_data.op = item.op;
    item_data.pixel_x = item.pixel_x;
    item_data.pixel_y = item.pixel_y;
    item_data.pixel_value = item.pixel_value;
    item_data.corner_x_a = item.corner_x_a;
    item_data.corner_x_b = item.corner_x_b;
    item_data.corner_y_a = item.corner_y_a;
    item_data.corner_y_b = item.corner_y_b;
    item_data.paint_color = item.paint_color;
  end

  assign cfg.ready = 1'b1;
  assign result.accepted = res.accepted;
  assign result.candidate_error = res.candidate_error;
  assign result.best_error = res.best_error;
  assign result.read_pixel = res.read_pixel;

  rhc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .st           (st),
    .cmd          (cmd)
  );

  rhc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item_data),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .st        (st),
    .res       (res)
  );

endmodule

`default_nettype wire

>>> tb/tb_rectangle_hill_climb_image_fit_top.sv
// ----------------------------------------------------------------------------
// Rectangle hill-climb image fit: testbench
// Sends load, step, read and idle items over several image sizes, with random
// gaps and stalls on both channels. A predictor keeps its own copies of the
// target image, the approximation and the lowest error, and each result
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rectangle_hill_climb_image_fit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 128;
  localparam int CYCLE_LIMIT = 200_000;

  logic clk = 1'b0;
  logic rst;

  rhc_item_if   item_ch ();
  rhc_result_if result_ch ();
  rhc_cfg_if    cfg_ch ();

  rectangle_hill_climb_image_fit_top #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [31:0] target_px [MAX_COLS*MAX_ROWS];
  logic [31:0] approx_px [MAX_COLS*MAX_ROWS];
  logic [24:0] lowest_error;
  logic [7:0]  width_reg;
  logic [7:0]  height_reg;

  result_t     awaited_results [$];
  int          error_count;
  int unsigned cycle_count;
  bit          no_idle;
  int          hold_request;
  int          hold_left;
  int          ready_gap;
  int          ready_draw;

  function automatic int active_cols();
    return (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
  endfunction

  function automatic int active_rows();
    return (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
  endfunction

  function automatic int unsigned rgba_distance(logic [31:0] a, logic [31:0] b);
    int unsigned sum;
    int          ca;
    int          cb;
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      ca = a[8*c +: 8];
      cb = b[8*c +: 8];
      sum += (ca > cb) ? ca - cb : cb - ca;
    end
    return sum;
  endfunction

  // Updates the predicted state and returns the result the item must give.
  function automatic result_t expected_fit_result(item_t it);
    result_t         r;
    int              cols;
    int              rows;
    int              x0;
    int              x1;
    int              y0;
    int              y1;
    longint unsigned total;
    logic [31:0]     shown;
    logic [13:0]     addr;
    r    = '0;
    addr = {it.pixel_y, it.pixel_x};
    case (it.op)
      OP_LOAD: target_px[addr] = it.pixel_value;
      OP_READ: r.read_pixel = approx_px[addr];
      OP_STEP: begin
        cols = active_cols();
        rows = active_rows();
        x0 = (it.corner_x_a < it.corner_x_b) ? it.corner_x_a : it.corner_x_b;
        x1 = (it.corner_x_a < it.corner_x_b) ? it.corner_x_b : it.corner_x_a;
        y0 = (it.corner_y_a < it.corner_y_b) ? it.corner_y_a : it.corner_y_b;
        y1 = (it.corner_y_a < it.corner_y_b) ? it.corner_y_b : it.corner_y_a;
        if (x1 > cols) x1 = cols;
        if (y1 > rows) y1 = rows;
        total = 0;
        for (int y = 0; y < rows; y++) begin
          for (int x = 0; x < cols; x++) begin
            addr  = 14'(y*MAX_COLS + x);
            shown = (x >= x0 && x < x1 && y >= y0 && y < y1) ? it.paint_color
                                                               : approx_px[addr];
            total += rgba_distance(shown, target_px[addr]);
          end
        end
        r.candidate_error = (total > ERR_SAT) ? ERR_SAT : total[23:0];
        if ({1'b0, r.candidate_error} < lowest_error) begin
          r.accepted   = 1'b1;
          lowest_error = {1'b0, r.candidate_error};
          for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++)
              approx_px[y*MAX_COLS + x] = it.paint_color;
        end
      end
      default: ;
    endcase
    r.best_error = lowest_error;
    return r;
  endfunction

  function automatic item_t random_item(op_t kind);
    item_t it;
    it.op          = kind;
    it.pixel_x     = 7'($urandom);
    it.pixel_y     = 7'($urandom);
    it.pixel_value = $urandom;
    it.corner_x_a  = 7'($urandom);
    it.corner_x_b  = 7'($urandom);
    it.corner_y_a  = 7'($urandom);
    it.corner_y_b  = 7'($urandom);
    it.paint_color = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] target_at(int cols, int rows);
    return target_px[$urandom_range(0, rows-1)*MAX_COLS + $urandom_range(0, cols-1)];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    error_count++;
  endtask

  task automatic send_item(item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= it.op;
    item_ch.pixel_x     <= it.pixel_x;
    item_ch.pixel_y     <= it.pixel_y;
    item_ch.pixel_value <= it.pixel_value;
    item_ch.corner_x_a  <= it.corner_x_a;
    item_ch.corner_x_b  <= it.corner_x_b;
    item_ch.corner_y_a  <= it.corner_y_a;
    item_ch.corner_y_b  <= it.corner_y_b;
    item_ch.paint_color <= it.paint_color;
    do @(posedge clk); while (!item_ch.ready);
    awaited_results.push_back(expected_fit_result(it));
  endtask

  task automatic await_all_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
    await_all_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
  endtask

  task automatic read_pixel_at(int x, int y);
    item_t it;
    it         = random_item(OP_READ);
    it.pixel_x = 7'(x);
    it.pixel_y = 7'(y);
    send_item(it);
  endtask

  task automatic load_pixel_at(int x, int y, logic [31:0] value);
    item_t it;
    it             = random_item(OP_LOAD);
    it.pixel_x     = 7'(x);
    it.pixel_y     = 7'(y);
    it.pixel_value = value;
    send_item(it);
  endtask

  // Loads every pixel of the active area as a base colour with some noise.
  task automatic load_target_area(logic [31:0] base, logic [31:0] noise);
    for (int y = 0; y < active_rows(); y++)
      for (int x = 0; x < active_cols(); x++)
        load_pixel_at(x, y, base ^ ($urandom & noise));
  endtask

  // The first proposal covers as much of the active area as the corners reach.
  task automatic propose_steps(int count);
    item_t it;
    int    cols;
    int    rows;
    cols = active_cols();
    rows = active_rows();
    for (int i = 0; i < count; i++) begin
      it = random_item(OP_STEP);
      if (i == 0) begin
        it.corner_x_a = 7'd0;
        it.corner_x_b = (cols > 127) ? 7'd127 : 7'(cols);
        it.corner_y_a = (rows > 127) ? 7'd127 : 7'(rows);
        it.corner_y_b = 7'd0;
      end
      if (cols > 0 && rows > 0 && $urandom_range(0, 2) != 0)
        it.paint_color = target_at(cols, rows);
      send_item(it);
    end
  endtask

  task automatic test_directed_ops();
    item_t it;
    write_register(REG_IMAGE_WIDTH, 8'd4);
    write_register(REG_IMAGE_HEIGHT, 8'd2);
    read_pixel_at(0, 0);
    read_pixel_at(127, 127);
    send_item(random_item(OP_NONE));
    load_pixel_at(127, 127, 32'hFFFF_FFFF);
    load_pixel_at(0, 127, 32'h0000_0000);
    read_pixel_at(127, 127);
    load_target_area($urandom, 32'hFFFF_FFFF);
    // Whole image, clipped to the active area, in white.
    it = random_item(OP_STEP);
    it.corner_x_a  = 7'd0;
    it.corner_x_b  = 7'd127;
    it.corner_y_a  = 7'd0;
    it.corner_y_b  = 7'd127;
    it.paint_color = 32'hFFFF_FFFF;
    send_item(it);
    // Equal corners paint nothing, so the error cannot drop.
    it = random_item(OP_STEP);
    it.corner_x_a  = 7'd2;
    it.corner_x_b  = 7'd2;
    it.corner_y_a  = 7'd1;
    it.corner_y_b  = 7'd1;
    it.paint_color = 32'h0000_0000;
    send_item(it);
    it = random_item(OP_STEP);
    it.corner_x_a  = 7'd3;
    it.corner_x_b  = 7'd1;
    it.corner_y_a  = 7'd2;
    it.corner_y_b  = 7'd0;
    it.paint_color = target_at(4, 2);
    send_item(it);
    // Wholly outside the active area.
    it = random_item(OP_STEP);
    it.corner_x_a = 7'd100;
    it.corner_x_b = 7'd127;
    it.corner_y_a = 7'd127;
    it.corner_y_b = 7'd64;
    send_item(it);
    it = random_item(OP_STEP);
    it.corner_x_a  = 7'd0;
    it.corner_x_b  = 7'd4;
    it.corner_y_a  = 7'd0;
    it.corner_y_b  = 7'd2;
    it.paint_color = target_px[0];
    send_item(it);
    read_pixel_at(1, 1);
    read_pixel_at(3, 1);
    read_pixel_at(4, 0);
  endtask

  // The receiver holds off while items keep coming, so the block stalls intake.
  task automatic test_backpressure();
    item_t it;
    await_all_results();
    no_idle      = 1'b1;
    hold_request = 200;
    for (int i = 0; i < 14; i++) begin
      case (i % 3)
        0: it = random_item(OP_READ);
        1: begin
          it = random_item(OP_LOAD);
          it.pixel_y = 7'($urandom_range(64, 127));
        end
        default: it = random_item(OP_STEP);
      endcase
      send_item(it);
    end
    await_all_results();
    no_idle = 1'b0;
  endtask

  // Shrinking near-uniform targets, so that good proposals keep being kept.
  task automatic test_random_fits();
    item_t       it;
    int          cols;
    int          rows;
    int          pick;
    logic [31:0] base;
    for (int phase = 0; phase < 2; phase++) begin
      write_register(REG_IMAGE_WIDTH, 8'(6 - 2*phase - $urandom_range(0, 1)));
      write_register(REG_IMAGE_HEIGHT, 8'(4 - phase - $urandom_range(0, 1)));
      no_idle = (phase == 1);
      cols = active_cols();
      rows = active_rows();
      base = $urandom;
      load_target_area(base, 32'h0303_0303);
      propose_steps(1);
      repeat (12) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it = random_item(OP_STEP);
          it.corner_x_a  = 7'($urandom_range(0, cols));
          it.corner_x_b  = 7'($urandom_range(0, cols));
          it.corner_y_a  = 7'($urandom_range(0, rows));
          it.corner_y_b  = 7'($urandom_range(0, rows));
          it.paint_color = target_at(cols, rows);
        end else if (pick < 50) begin
          it = random_item(OP_STEP);
        end else if (pick < 70) begin
          it = random_item(OP_LOAD);
          it.pixel_x     = 7'($urandom_range(0, cols-1));
          it.pixel_y     = 7'($urandom_range(0, rows-1));
          it.pixel_value = base ^ ($urandom & 32'h0303_0303);
        end else if (pick < 75) begin
          it = random_item(OP_LOAD);
        end else if (pick < 92) begin
          it = random_item(OP_READ);
          if (pick < 84) begin
            it.pixel_x = 7'($urandom_range(0, cols-1));
            it.pixel_y = 7'($urandom_range(0, rows-1));
          end
        end else begin
          it = random_item(OP_NONE);
        end
        send_item(it);
      end
    end
    no_idle = 1'b0;
  endtask

  // A single active pixel.
  task automatic test_extreme_sizes();
    write_register(REG_IMAGE_WIDTH, 8'd1);
    write_register(REG_IMAGE_HEIGHT, 8'd1);
    load_target_area($urandom, 32'h0707_0707);
    propose_steps(3);
    read_pixel_at(0, 0);
  endtask

  // An empty area gives zero error, after which nothing can be kept again.
  task automatic test_empty_area();
    write_register(REG_IMAGE_WIDTH, 8'd0);
    write_register(REG_IMAGE_HEIGHT, 8'd5);
    propose_steps(2);
    read_pixel_at(0, 0);
    write_register(REG_IMAGE_WIDTH, 8'd200);
    write_register(REG_IMAGE_HEIGHT, 8'd0);
    propose_steps(2);
    read_pixel_at(1, 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      ready_gap       <= 0;
    end else if (hold_request != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_request;
      hold_request     = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
    end else if (!result_ch.ready) begin
      result_ch.ready <= 1'b1;
    end else if (result_ch.valid) begin
      ready_draw = no_idle ? 0 : $urandom_range(0, 5);
      if (ready_draw > 0) begin
        result_ch.ready <= 1'b0;
        ready_gap       <= ready_draw - 1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'd0, result_ch.best_error);
      end else begin
        want = awaited_results.pop_front();
        if (result_ch.accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, result_ch.accepted);
        if (result_ch.candidate_error !== want.candidate_error)
          report_mismatch("candidate_error", want.candidate_error,
                          result_ch.candidate_error);
        if (result_ch.best_error !== want.best_error)
          report_mismatch("best_error", want.best_error, result_ch.best_error);
        if (result_ch.read_pixel !== want.read_pixel)
          report_mismatch("read_pixel", want.read_pixel, result_ch.read_pixel);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) begin
      target_px[i] = '0;
      approx_px[i] = BLACK_PIXEL;
    end
    lowest_error        = BEST_ALL_ONES;
    width_reg           = DIM_RESET;
    height_reg          = DIM_RESET;
    error_count         = 0;
    no_idle             = 1'b0;
    hold_request        = 0;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.op          = OP_NONE;
    item_ch.pixel_x     = '0;
    item_ch.pixel_y     = '0;
    item_ch.pixel_value = '0;
    item_ch.corner_x_a  = '0;
    item_ch.corner_x_b  = '0;
    item_ch.corner_y_a  = '0;
    item_ch.corner_y_b  = '0;
    item_ch.paint_color = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_IMAGE_WIDTH;
    cfg_ch.data         = '0;
    result_ch.ready     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_backpressure();
    test_random_fits();
    test_extreme_sizes();
    test_empty_area();

    await_all_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> rectangle_hill_climb_image_fit_top.f
hdl/rhc_pkg.sv
hdl/rhc_if.sv
hdl/rhc_datapath.sv
hdl/rhc_ctrl.sv
hdl/rectangle_hill_climb_image_fit_top.sv
tb/tb_rectangle_hill_climb_image_fit_top.sv
